>>> rtl/dcrf_pkg.sv
// shared beat types and register field constants for the dma channel register file
package dcrf_pkg;

	// command codes
	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	// register selector codes
	localparam logic [1:0] REG_SRC = 2'd0;
	localparam logic [1:0] REG_DST = 2'd1;
	localparam logic [1:0] REG_CTL = 2'd2;

	// per-side address control codes; the other two codes keep the address fixed
	localparam logic [1:0] ACTL_INC = 2'd0;
	localparam logic [1:0] ACTL_DEC = 2'd1;

	// transfer mode that issues a descriptor at once
	localparam logic [2:0] MODE_IMM = 3'd0;

	// control word layout
	localparam int CTL_ENABLE  = 31;
	localparam int CTL_IRQ_EN  = 30;
	localparam int CTL_MODE_HI = 29;
	localparam int CTL_MODE_LO = 27;
	localparam int CTL_WIDE    = 26;
	localparam int CTL_SACT_HI = 24;
	localparam int CTL_SACT_LO = 23;
	localparam int CTL_DACT_HI = 22;
	localparam int CTL_DACT_LO = 21;
	localparam int CTL_CNT_HI  = 20;

	localparam logic [31:0] ADDR_MASK  = 32'h07FF_FFFF;
	localparam logic [21:0] COUNT_ZERO = 22'h20_0000;

	// step values in bytes per unit
	localparam logic signed [3:0] STEP_HALF = 4'sd2;
	localparam logic signed [3:0] STEP_WORD = 4'sd4;

	typedef struct packed {
		logic        cmd;
		logic        cpu_sel;
		logic [1:0]  chan;
		logic [1:0]  reg_sel;
		logic [31:0] wdata;
	} req_t;

	typedef struct packed {
		logic [31:0]       rdata;
		logic              xfer_valid;
		logic [31:0]       xfer_src;
		logic [31:0]       xfer_dst;
		logic [21:0]       xfer_count;
		logic              xfer_wide;
		logic signed [3:0] src_step;
		logic signed [3:0] dst_step;
		logic              irq_valid;
		logic              irq_cpu;
		logic [1:0]        irq_chan;
	} rsp_t;

endpackage

>>> rtl/dma_channel_register_file.sv
// top level: register file of a two-bank dma controller with immediate descriptor issue
//
// Each of the two cpu banks owns CHANNELS channels with a source, destination and control
// register. Every request beat produces exactly one response beat: a read returns the
// register (control bit 31 reads 0 while the channel is idle), a write returns zero
// read data. A control write whose enable bit rises starts the channel; in immediate mode
// the response carries a copy descriptor (start addresses, count, unit size, signed steps)
// and, with bit 30 set, an interrupt request, while the stored addresses advance past the
// copied block. One beat is accepted every cycle while the response side drains; a beat
// waits in the input register, where the slot state is read and written back, then moves
// into the response register. A stalled response holds the input register, and ready drops
// only once both registers are full.
module dma_channel_register_file #(
	parameter int CHANNELS = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dcrf_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output dcrf_pkg::rsp_t out_data
);

	localparam int SLOTS  = 2 * CHANNELS;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [2:0] CHAN_LIMIT = 3'(CHANNELS);
	localparam logic [3:0] CHAN_MULT  = 4'(CHANNELS);

	// per-slot architectural state, slot = bank * CHANNELS + channel
	logic [31:0]      src_q [SLOTS];
	logic [31:0]      dst_q [SLOTS];
	logic [31:0]      ctl_q [SLOTS];
	logic [SLOTS-1:0] busy_q;

	// input register
	logic           valid_s1;
	dcrf_pkg::req_t req_s1;

	// response register
	logic           out_valid_q;
	dcrf_pkg::rsp_t rsp_q;

	logic              advance;
	logic              in_range;
	logic [3:0]        slot_full;
	logic [SLOT_W-1:0] slot;
	logic [31:0]       src_cur;
	logic [31:0]       dst_cur;
	logic [31:0]       ctl_cur;
	logic              busy_cur;
	logic              is_write;
	logic              start;
	logic              imm;
	logic [21:0]       count;
	logic              wide;
	logic [31:0]       offset;
	logic [31:0]       src_next;
	logic [31:0]       dst_next;
	logic signed [3:0] size_step;
	logic signed [3:0] src_step;
	logic signed [3:0] dst_step;
	dcrf_pkg::rsp_t    rsp_d;

	// the input register moves on whenever the response register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// slot lookup
	assign in_range  = {1'b0, req_s1.chan} < CHAN_LIMIT;
	assign slot_full = {3'b000, req_s1.cpu_sel} * CHAN_MULT + {2'b00, req_s1.chan};
	assign slot      = slot_full[SLOT_W-1:0];
	assign src_cur   = src_q[slot];
	assign dst_cur   = dst_q[slot];
	assign ctl_cur   = ctl_q[slot];
	assign busy_cur  = busy_q[slot];

	// start detection: enable rises against the stored control word
	assign is_write = in_range && (req_s1.cmd == dcrf_pkg::CMD_WRITE);
	assign start    = is_write && (req_s1.reg_sel == dcrf_pkg::REG_CTL)
		&& !ctl_cur[dcrf_pkg::CTL_ENABLE] && req_s1.wdata[dcrf_pkg::CTL_ENABLE];
	assign imm      = start
		&& (req_s1.wdata[dcrf_pkg::CTL_MODE_HI:dcrf_pkg::CTL_MODE_LO] == dcrf_pkg::MODE_IMM);

	// count of zero means the largest block
	assign count = (req_s1.wdata[dcrf_pkg::CTL_CNT_HI:0] == 21'd0) ? dcrf_pkg::COUNT_ZERO
		: {1'b0, req_s1.wdata[dcrf_pkg::CTL_CNT_HI:0]};
	assign wide  = req_s1.wdata[dcrf_pkg::CTL_WIDE];

	// count times unit size is a shift by one or two
	assign offset    = wide ? {8'd0, count, 2'b00} : {9'd0, count, 1'b0};
	assign size_step = wide ? dcrf_pkg::STEP_WORD : dcrf_pkg::STEP_HALF;

	always_comb begin
		case (req_s1.wdata[dcrf_pkg::CTL_SACT_HI:dcrf_pkg::CTL_SACT_LO])
			dcrf_pkg::ACTL_INC: begin
				src_next = src_cur + offset;
				src_step = size_step;
			end
			dcrf_pkg::ACTL_DEC: begin
				src_next = src_cur - offset;
				src_step = -size_step;
			end
			default: begin
				src_next = src_cur;
				src_step = 4'sd0;
			end
		endcase
	end

	always_comb begin
		case (req_s1.wdata[dcrf_pkg::CTL_DACT_HI:dcrf_pkg::CTL_DACT_LO])
			dcrf_pkg::ACTL_INC: begin
				dst_next = dst_cur + offset;
				dst_step = size_step;
			end
			dcrf_pkg::ACTL_DEC: begin
				dst_next = dst_cur - offset;
				dst_step = -size_step;
			end
			default: begin
				dst_next = dst_cur;
				dst_step = 4'sd0;
			end
		endcase
	end

	// response beat
	always_comb begin
		rsp_d = '0;
		if (in_range && (req_s1.cmd == dcrf_pkg::CMD_READ)) begin
			case (req_s1.reg_sel)
				dcrf_pkg::REG_SRC: rsp_d.rdata = src_cur;
				dcrf_pkg::REG_DST: rsp_d.rdata = dst_cur;
				dcrf_pkg::REG_CTL: begin
					// enable reads back only while the channel is busy
					rsp_d.rdata = {ctl_cur[dcrf_pkg::CTL_ENABLE] & busy_cur, ctl_cur[30:0]};
				end
				default: rsp_d.rdata = '0;
			endcase
		end
		if (imm) begin
			rsp_d.xfer_valid = 1'b1;
			rsp_d.xfer_src   = src_cur;
			rsp_d.xfer_dst   = dst_cur;
			rsp_d.xfer_count = count;
			rsp_d.xfer_wide  = wide;
			rsp_d.src_step   = src_step;
			rsp_d.dst_step   = dst_step;
			if (req_s1.wdata[dcrf_pkg::CTL_IRQ_EN]) begin
				rsp_d.irq_valid = 1'b1;
				rsp_d.irq_cpu   = req_s1.cpu_sel;
				rsp_d.irq_chan  = req_s1.chan;
			end
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= in_data;
		end
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	// slot state, written as the beat leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				src_q[i] <= '0;
				dst_q[i] <= '0;
				ctl_q[i] <= '0;
			end
			busy_q <= '0;
		end else if (advance && is_write) begin
			case (req_s1.reg_sel)
				dcrf_pkg::REG_SRC: src_q[slot] <= req_s1.wdata & dcrf_pkg::ADDR_MASK;
				dcrf_pkg::REG_DST: dst_q[slot] <= req_s1.wdata & dcrf_pkg::ADDR_MASK;
				dcrf_pkg::REG_CTL: begin
					// immediate mode finishes at once and drops enable
					ctl_q[slot] <= imm ? {1'b0, req_s1.wdata[30:0]} : req_s1.wdata;
					if (start) begin
						busy_q[slot] <= !imm;
					end
					if (imm) begin
						src_q[slot] <= src_next;
						dst_q[slot] <= dst_next;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = rsp_q;

endmodule

>>> rtl/dcrf_checker.sv
// port-level checker for the dma channel register file, with its bind
module dcrf_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input dcrf_pkg::rsp_t out_data
);

	// a stalled response beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response beat changed while stalled");

	// an interrupt only comes with an issued descriptor
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.irq_valid |-> out_data.xfer_valid)
		else $error("interrupt without descriptor");

	// a descriptor comes from a write and carries a legal count
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.xfer_valid |-> out_data.rdata == 32'd0
			&& out_data.xfer_count != 22'd0
			&& out_data.xfer_count <= dcrf_pkg::COUNT_ZERO)
		else $error("bad descriptor beat");

	// descriptor fields are quiet when no descriptor is issued
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.xfer_valid |-> out_data.xfer_count == 22'd0
			&& out_data.src_step == 4'sd0 && out_data.dst_step == 4'sd0
			&& out_data.xfer_src == 32'd0 && out_data.xfer_dst == 32'd0)
		else $error("descriptor fields set without descriptor");

endmodule

bind dma_channel_register_file dcrf_checker u_dcrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

>>> bench/tb.sv
// self-checking bench for the dma channel register file: directed and random bus beats
module tb;

	// one cpu bank holds this many channels, matching the default of the block
	localparam int NCHAN = 4;
	localparam int NSLOT = 2 * NCHAN;

	// selector code that maps to no register
	localparam logic [1:0] REG_NONE = 2'd3;

	// bank codes
	localparam logic BANK_SUB  = 1'b0;
	localparam logic BANK_MAIN = 1'b1;

	// address control codes that hold the address still
	localparam logic [1:0] ACTL_FIX_A = 2'd2;
	localparam logic [1:0] ACTL_FIX_B = 2'd3;

	// a mode other than immediate, left pending by the block
	localparam logic [2:0] MODE_PEND = 3'd7;

	// generous cycle budget, several times the slowest correct run
	localparam int CYCLE_LIMIT = 400000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	dcrf_pkg::req_t   in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	dcrf_pkg::rsp_t   out_data;

	// channel registers as the bus sees them, one slot per bank and channel
	logic [31:0] src_reg [NSLOT];
	logic [31:0] dst_reg [NSLOT];
	logic [31:0] ctl_reg [NSLOT];
	logic        busy    [NSLOT];

	// response beats still owed by the block, oldest first
	dcrf_pkg::rsp_t owed_rsp [$];

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned rx_hold_left = 0;
	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned beat_count = 0;
	int unsigned xfer_count_seen = 0;
	int unsigned irq_count_seen = 0;

	dma_channel_register_file u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// behavior of the register file, kept in step with accepted request beats
	// ---------------------------------------------------------------------

	// signed byte step of one side from its address control and the unit size
	function automatic logic signed [3:0] unit_step(logic [1:0] actl, logic wide);
		logic signed [3:0] sz;
		sz = wide ? dcrf_pkg::STEP_WORD : dcrf_pkg::STEP_HALF;
		case (actl)
			dcrf_pkg::ACTL_INC: return sz;
			dcrf_pkg::ACTL_DEC: return -sz;
			default:  return 4'sd0;
		endcase
	endfunction

	// apply one bus access to the mirrored registers and return its response beat
	function automatic dcrf_pkg::rsp_t bus_access(dcrf_pkg::req_t r);
		dcrf_pkg::rsp_t    o;
		int unsigned       k;
		logic              rising;
		logic [21:0]       cnt;
		logic signed [3:0] ss;
		logic signed [3:0] ds;
		o = '0;
		if (r.chan >= NCHAN)
			return o;
		k = r.cpu_sel * NCHAN + r.chan;
		if (r.cmd == dcrf_pkg::CMD_READ) begin
			case (r.reg_sel)
				dcrf_pkg::REG_SRC: o.rdata = src_reg[k];
				dcrf_pkg::REG_DST: o.rdata = dst_reg[k];
				dcrf_pkg::REG_CTL: begin
					o.rdata = ctl_reg[k];
					// enable reads back 0 unless the channel is still busy
					if (!busy[k])
						o.rdata[dcrf_pkg::CTL_ENABLE] = 1'b0;
				end
				default: o.rdata = '0;
			endcase
			return o;
		end
		case (r.reg_sel)
			dcrf_pkg::REG_SRC: src_reg[k] = r.wdata & dcrf_pkg::ADDR_MASK;
			dcrf_pkg::REG_DST: dst_reg[k] = r.wdata & dcrf_pkg::ADDR_MASK;
			dcrf_pkg::REG_CTL: begin
				rising = !ctl_reg[k][dcrf_pkg::CTL_ENABLE] && r.wdata[dcrf_pkg::CTL_ENABLE];
				ctl_reg[k] = r.wdata;
				if (rising) begin
					busy[k] = 1'b1;
					cnt = {1'b0, r.wdata[dcrf_pkg::CTL_CNT_HI:0]};
					if (cnt == '0)
						cnt = dcrf_pkg::COUNT_ZERO;
					if (r.wdata[dcrf_pkg::CTL_MODE_HI:dcrf_pkg::CTL_MODE_LO]
						== dcrf_pkg::MODE_IMM) begin
						ss = unit_step(r.wdata[dcrf_pkg::CTL_SACT_HI:dcrf_pkg::CTL_SACT_LO],
							r.wdata[dcrf_pkg::CTL_WIDE]);
						ds = unit_step(r.wdata[dcrf_pkg::CTL_DACT_HI:dcrf_pkg::CTL_DACT_LO],
							r.wdata[dcrf_pkg::CTL_WIDE]);
						o.xfer_valid = 1'b1;
						o.xfer_src   = src_reg[k];
						o.xfer_dst   = dst_reg[k];
						o.xfer_count = cnt;
						o.xfer_wide  = r.wdata[dcrf_pkg::CTL_WIDE];
						o.src_step   = ss;
						o.dst_step   = ds;
						// addresses move past the copied block, wrapping at 32 bits
						src_reg[k] = src_reg[k] + 32'(cnt) * {{28{ss[3]}}, ss};
						dst_reg[k] = dst_reg[k] + 32'(cnt) * {{28{ds[3]}}, ds};
						busy[k] = 1'b0;
						ctl_reg[k][dcrf_pkg::CTL_ENABLE] = 1'b0;
						if (ctl_reg[k][dcrf_pkg::CTL_IRQ_EN]) begin
							o.irq_valid = 1'b1;
							o.irq_cpu   = r.cpu_sel;
							o.irq_chan  = r.chan;
						end
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	// ---------------------------------------------------------------------
	// response checking
	// ---------------------------------------------------------------------

	function automatic string field_diff(dcrf_pkg::rsp_t e, dcrf_pkg::rsp_t g);
		string s;
		s = "";
		if (g.rdata !== e.rdata)
			s = {s, $sformatf(" rdata %h/%h", e.rdata, g.rdata)};
		if (g.xfer_valid !== e.xfer_valid)
			s = {s, $sformatf(" xfer_valid %b/%b", e.xfer_valid, g.xfer_valid)};
		if (g.xfer_src !== e.xfer_src)
			s = {s, $sformatf(" xfer_src %h/%h", e.xfer_src, g.xfer_src)};
		if (g.xfer_dst !== e.xfer_dst)
			s = {s, $sformatf(" xfer_dst %h/%h", e.xfer_dst, g.xfer_dst)};
		if (g.xfer_count !== e.xfer_count)
			s = {s, $sformatf(" xfer_count %h/%h", e.xfer_count, g.xfer_count)};
		if (g.xfer_wide !== e.xfer_wide)
			s = {s, $sformatf(" xfer_wide %b/%b", e.xfer_wide, g.xfer_wide)};
		if (g.src_step !== e.src_step)
			s = {s, $sformatf(" src_step %0d/%0d", e.src_step, g.src_step)};
		if (g.dst_step !== e.dst_step)
			s = {s, $sformatf(" dst_step %0d/%0d", e.dst_step, g.dst_step)};
		if (g.irq_valid !== e.irq_valid)
			s = {s, $sformatf(" irq_valid %b/%b", e.irq_valid, g.irq_valid)};
		if (g.irq_cpu !== e.irq_cpu)
			s = {s, $sformatf(" irq_cpu %b/%b", e.irq_cpu, g.irq_cpu)};
		if (g.irq_chan !== e.irq_chan)
			s = {s, $sformatf(" irq_chan %0d/%0d", e.irq_chan, g.irq_chan)};
		return s;
	endfunction

	// only the first ten mismatches are printed, the rest are counted
	task automatic note_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at cycle %0d (expected/actual):%s", cycle_count, what);
	endtask

	// every response beat is matched against the oldest owed one
	always @(posedge clk) begin : rsp_check
		dcrf_pkg::rsp_t want;
		string          diff;
		if (arst_n && out_valid && out_ready) begin
			beat_count++;
			if (owed_rsp.size() == 0) begin
				note_mismatch($sformatf(" response beat with nothing owed, rdata %h",
					out_data.rdata));
			end else begin
				want = owed_rsp.pop_front();
				if (want.xfer_valid)
					xfer_count_seen++;
				if (want.irq_valid)
					irq_count_seen++;
				diff = field_diff(want, out_data);
				if (diff != "")
					note_mismatch(diff);
			end
		end
	end

	// ---------------------------------------------------------------------
	// output side: random stalls, plus a counted long hold when asked for
	// ---------------------------------------------------------------------

	always @(negedge clk) begin
		if (rx_hold_left != 0) begin
			out_ready <= 1'b0;
			rx_hold_left--;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// run length guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still owed", cycle_count,
				owed_rsp.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// request side
	// ---------------------------------------------------------------------

	// offer one request beat, idling first at random; valid stays up into the
	// next call so back-to-back beats never lower and raise it in one step
	task automatic send_beat(dcrf_pkg::req_t r);
		@(negedge clk);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		owed_rsp.push_back(bus_access(r));
	endtask

	task automatic bus_rd(logic bank, logic [1:0] ch, logic [1:0] rs);
		dcrf_pkg::req_t r;
		r = '{cmd: dcrf_pkg::CMD_READ, cpu_sel: bank, chan: ch, reg_sel: rs,
			wdata: $urandom()};
		send_beat(r);
	endtask

	task automatic bus_wr(logic bank, logic [1:0] ch, logic [1:0] rs, logic [31:0] wd);
		dcrf_pkg::req_t r;
		r = '{cmd: dcrf_pkg::CMD_WRITE, cpu_sel: bank, chan: ch, reg_sel: rs, wdata: wd};
		send_beat(r);
	endtask

	// control word from its fields; bit 25 is the repeat bit, which the block ignores
	function automatic logic [31:0] ctl_word(logic en, logic irq, logic [2:0] mode,
		logic wide, logic rpt, logic [1:0] sact, logic [1:0] dact, logic [20:0] cnt);
		return {en, irq, mode, wide, rpt, sact, dact, cnt};
	endfunction

	// random access, mostly to real registers, with control writes leaning to
	// immediate starts so descriptors and address roll-over come often
	function automatic dcrf_pkg::req_t random_access();
		dcrf_pkg::req_t r;
		int unsigned    pick;
		r.cmd     = 1'($urandom_range(1));
		r.cpu_sel = 1'($urandom_range(1));
		r.chan    = 2'($urandom_range(3));
		r.wdata   = $urandom();
		pick = $urandom_range(99);
		if (pick < 25)
			r.reg_sel = dcrf_pkg::REG_SRC;
		else if (pick < 50)
			r.reg_sel = dcrf_pkg::REG_DST;
		else if (pick < 97)
			r.reg_sel = dcrf_pkg::REG_CTL;
		else
			r.reg_sel = REG_NONE;
		if (r.reg_sel == dcrf_pkg::REG_CTL && $urandom_range(99) < 65)
			r.wdata[dcrf_pkg::CTL_MODE_HI:dcrf_pkg::CTL_MODE_LO] = dcrf_pkg::MODE_IMM;
		if (r.reg_sel == dcrf_pkg::REG_CTL && $urandom_range(99) < 50)
			r.wdata[dcrf_pkg::CTL_CNT_HI:0] = 21'($urandom_range(16));
		return r;
	endfunction

	// stop offering, then wait until every owed beat has come back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (owed_rsp.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------

	// registers read zero after reset, and the unused selector reads zero
	task automatic test_reset_values();
		bus_rd(BANK_SUB, 2'd0, dcrf_pkg::REG_CTL);
		bus_rd(BANK_MAIN, 2'd3, REG_NONE);
		bus_rd(BANK_MAIN, 2'd2, dcrf_pkg::REG_SRC);
	endtask

	// address writes keep 27 bits; writes to the unused selector go nowhere
	task automatic test_address_masking();
		bus_wr(BANK_MAIN, 2'd3, dcrf_pkg::REG_SRC, 32'hFFFF_FFFF);
		bus_wr(BANK_MAIN, 2'd3, dcrf_pkg::REG_DST, 32'hF800_0000);
		bus_wr(BANK_MAIN, 2'd3, REG_NONE, 32'hFFFF_FFFF);
		bus_rd(BANK_MAIN, 2'd3, dcrf_pkg::REG_SRC);
		bus_rd(BANK_MAIN, 2'd3, dcrf_pkg::REG_DST);
		bus_rd(BANK_MAIN, 2'd3, REG_NONE);
	endtask

	// immediate starts: zero count means the full 0x200000, largest and
	// smallest count, every address control, both unit sizes, irq on and off
	task automatic test_immediate_issue();
		// word units, source up and destination down from zero so it wraps
		bus_wr(BANK_MAIN, 2'd3, dcrf_pkg::REG_CTL,
			ctl_word(1'b1, 1'b1, dcrf_pkg::MODE_IMM, 1'b1, 1'b1, dcrf_pkg::ACTL_INC,
				dcrf_pkg::ACTL_DEC, 21'd0));
		bus_rd(BANK_MAIN, 2'd3, dcrf_pkg::REG_SRC);
		bus_rd(BANK_MAIN, 2'd3, dcrf_pkg::REG_DST);
		bus_rd(BANK_MAIN, 2'd3, dcrf_pkg::REG_CTL);
		bus_wr(BANK_SUB, 2'd0, dcrf_pkg::REG_CTL,
			ctl_word(1'b1, 1'b0, dcrf_pkg::MODE_IMM, 1'b0, 1'b0, ACTL_FIX_A, ACTL_FIX_B,
				21'h1F_FFFF));
		bus_wr(BANK_SUB, 2'd1, dcrf_pkg::REG_SRC, 32'h0000_0010);
		bus_wr(BANK_SUB, 2'd1, dcrf_pkg::REG_CTL,
			ctl_word(1'b1, 1'b1, dcrf_pkg::MODE_IMM, 1'b0, 1'b0, dcrf_pkg::ACTL_DEC,
				dcrf_pkg::ACTL_INC, 21'd1));
		bus_rd(BANK_SUB, 2'd1, dcrf_pkg::REG_SRC);
	endtask

	// a non-immediate start stays busy and is not restarted until enable is cleared
	task automatic test_pending_channel();
		bus_wr(BANK_SUB, 2'd2, dcrf_pkg::REG_CTL,
			ctl_word(1'b1, 1'b1, MODE_PEND, 1'b1, 1'b0, dcrf_pkg::ACTL_INC,
				dcrf_pkg::ACTL_INC, 21'd5));
		bus_rd(BANK_SUB, 2'd2, dcrf_pkg::REG_CTL);
		bus_wr(BANK_SUB, 2'd2, dcrf_pkg::REG_CTL,
			ctl_word(1'b1, 1'b1, dcrf_pkg::MODE_IMM, 1'b1, 1'b0, dcrf_pkg::ACTL_INC,
				dcrf_pkg::ACTL_INC, 21'd5));
		bus_wr(BANK_SUB, 2'd2, dcrf_pkg::REG_CTL,
			ctl_word(1'b0, 1'b1, dcrf_pkg::MODE_IMM, 1'b1, 1'b0, dcrf_pkg::ACTL_INC,
				dcrf_pkg::ACTL_INC, 21'd5));
		bus_rd(BANK_SUB, 2'd2, dcrf_pkg::REG_CTL);
		bus_wr(BANK_SUB, 2'd2, dcrf_pkg::REG_CTL,
			ctl_word(1'b1, 1'b1, dcrf_pkg::MODE_IMM, 1'b1, 1'b0, dcrf_pkg::ACTL_INC,
				dcrf_pkg::ACTL_INC, 21'd5));
		bus_wr(BANK_MAIN, 2'd0, dcrf_pkg::REG_CTL, 32'hFFFF_FFFF);
		bus_rd(BANK_MAIN, 2'd0, dcrf_pkg::REG_CTL);
	endtask

	task automatic test_random_traffic(int unsigned n, int unsigned tx_pct,
		int unsigned rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (n)
			send_beat(random_access());
	endtask

	// output held off for a long counted stretch while requests keep coming,
	// so both pipeline stages fill and the input stalls
	task automatic test_output_stall();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_left = 300;
		repeat (40)
			send_beat(random_access());
	endtask

	// requests pause until every owed response has come back, then resume
	task automatic test_pause_until_drained();
		tx_idle_pct = 10;
		rx_idle_pct = 30;
		repeat (20)
			send_beat(random_access());
		wait_drained();
		repeat (20)
			send_beat(random_access());
	endtask

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			src_reg[i] = '0;
			dst_reg[i] = '0;
			ctl_reg[i] = '0;
			busy[i]    = 1'b0;
		end
		// reset held low from time zero, released at a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_address_masking();
		test_immediate_issue();
		test_pending_channel();
		test_random_traffic(520, 27, 54);
		test_random_traffic(520, 54, 27);
		test_random_traffic(520, 0, 0);
		test_output_stall();
		test_pause_until_drained();

		// stop offering, let the owed beats arrive, then check that none is left
		@(negedge clk);
		in_valid <= 1'b0;
		rx_idle_pct = 0;
		wait_drained();
		repeat (8) @(posedge clk);
		if (owed_rsp.size() != 0)
			note_mismatch($sformatf(" %0d response beats never arrived", owed_rsp.size()));

		$display("covered %0d response beats: %0d descriptors, %0d interrupts", beat_count,
			xfer_count_seen, irq_count_seen);
		$display("under three idle mixes, a long output stall and a full drain pause");
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
